/* sv/poisson_inverse_sampler_top_assert.svh */
// assertion macros for the poisson inverse sampler
`ifndef POISSON_INVERSE_SAMPLER_TOP_ASSERT_SVH
`define POISSON_INVERSE_SAMPLER_TOP_ASSERT_SVH

// clocked property, held off during reset
`define PIS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// same-cycle implication
`define PIS_ASSERT_IMPL(lbl, ante, cons, msg) \
    `PIS_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

/* sv/pis_pkg.sv */
// shared types and constants of the poisson inverse sampler
package pis_pkg;

    // product term*lambda shifted right by 24 is the dividend
    localparam int NUM_W     = 40;
    localparam int DIGIT_W   = 8;
    localparam int NUM_CELLS = NUM_W / DIGIT_W;
    localparam int TERM_W    = 32;
    localparam int SUM_W     = 33;
    localparam int COUNT_W   = 5;
    localparam int PADDR_W   = 3;

    localparam logic [0:0] REG_RATE  = 1'b0;
    localparam logic [0:0] REG_FIRST = 1'b1;

    localparam logic [31:0] RATE_RESET  = 32'd16777216;
    localparam logic [31:0] FIRST_RESET = 32'd1580030169;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic launch;
        logic load_first;
        logic step;
        logic load_out;
    } ctrl_t;

endpackage

/* sv/pis_div_cell.sv */
// one cell of the divider chain: resolves eight quotient bits per pass
module pis_div_cell #(
    parameter int DIV_W = 5
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    input  logic [pis_pkg::NUM_W-1:0] in_num,
    input  logic [DIV_W-1:0]          in_rem,
    input  logic [pis_pkg::NUM_W-1:0] in_quo,
    input  logic [DIV_W-1:0]          in_div,
    output logic                      out_valid,
    output logic [pis_pkg::NUM_W-1:0] out_num,
    output logic [DIV_W-1:0]          out_rem,
    output logic [pis_pkg::NUM_W-1:0] out_quo,
    output logic [DIV_W-1:0]          out_div
);

    logic                        valid_reg;
    logic [pis_pkg::NUM_W-1:0]   num_reg, quo_reg;
    logic [DIV_W-1:0]            rem_reg, div_reg;
    logic [DIV_W:0]              rem_work;
    logic [pis_pkg::DIGIT_W-1:0] digit;

    // restoring division, one bit per step
    always_comb begin
        rem_work = {1'b0, in_rem};
        digit    = '0;
        for (int k = 0; k < pis_pkg::DIGIT_W; k++) begin
            rem_work = {rem_work[DIV_W-1:0], in_num[pis_pkg::NUM_W-1-k]};
            if (rem_work >= {1'b0, in_div}) begin
                rem_work = rem_work - {1'b0, in_div};
                digit[pis_pkg::DIGIT_W-1-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= in_num << pis_pkg::DIGIT_W;
        rem_reg <= rem_work[DIV_W-1:0];
        quo_reg <= {in_quo[pis_pkg::NUM_W-pis_pkg::DIGIT_W-1:0], digit};
        div_reg <= in_div;
    end

    assign out_valid = valid_reg;
    assign out_num   = num_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_div   = div_reg;

endmodule

/* sv/poisson_inverse_sampler_top.sv */
// Poisson sampler by sequential-search inversion over a chain of divider cells.
// One transaction at a time: term 0 is added to the sum and compared first;
// each further term passes the 32x32 multiplier, the divider chain that divides
// the product, shifted right by 24, by the term index, a load of the quotient
// as the new term, and an add to the sum with a compare. When a term hits, or
// the last term is reached for a not-found result, the result register is
// loaded. The input side is ready again while the result waits in its register
// to be taken.
module poisson_inverse_sampler_top #(
    parameter int MAX_TERMS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pis_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [31:0]                   s_uniform_fraction,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pis_pkg::COUNT_W-1:0]   m_sample_count,
    output logic                          m_not_found
);

    localparam int IDX_W = $clog2(MAX_TERMS);
    localparam int NC    = pis_pkg::NUM_CELLS;

    pis_pkg::state_t state_reg, state_next;
    pis_pkg::ctrl_t  ctrl;

    logic [31:0]                 rate_reg, first_reg;
    logic [31:0]                 u_reg;
    logic [pis_pkg::TERM_W-1:0]  term_reg;
    logic [pis_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [IDX_W-1:0]            idx_reg;
    logic [pis_pkg::NUM_W-1:0]   p24_reg;
    logic [63:0]                 product;
    logic                        launch_reg;
    logic                        hit, last;
    logic                        found_reg;
    logic                        m_valid_reg, m_nf_reg;
    logic [pis_pkg::COUNT_W-1:0] m_cnt_reg;
    logic [pis_pkg::TERM_W-1:0]  new_term;

    logic                        c_valid [0:NC];
    logic [pis_pkg::NUM_W-1:0]   c_num   [0:NC];
    logic [IDX_W-1:0]            c_rem   [0:NC];
    logic [pis_pkg::NUM_W-1:0]   c_quo   [0:NC];
    logic [IDX_W-1:0]            c_div   [0:NC];

    // configuration port
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg  <= pis_pkg::RATE_RESET;
            first_reg <= pis_pkg::FIRST_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                pis_pkg::REG_RATE:  rate_reg  <= pwdata;
                pis_pkg::REG_FIRST: first_reg <= pwdata;
                default: ;
            endcase
        end
    end
    assign prdata = (paddr[2] == pis_pkg::REG_FIRST) ? first_reg : rate_reg;

    assign sum_next = sum_reg + {1'b0, term_reg};
    assign hit      = {1'b0, u_reg} < sum_next;
    assign last     = idx_reg == IDX_W'(MAX_TERMS - 1);
    assign product  = {32'd0, term_reg} * {32'd0, rate_reg};
    assign new_term = (|c_quo[NC][pis_pkg::NUM_W-1:pis_pkg::TERM_W])
                      ? '1 : c_quo[NC][pis_pkg::TERM_W-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pis_pkg::ST_IDLE: if (s_valid) state_next = pis_pkg::ST_ACC;
            pis_pkg::ST_ACC:  state_next = (hit || last) ? pis_pkg::ST_DONE : pis_pkg::ST_MUL;
            pis_pkg::ST_MUL:  state_next = pis_pkg::ST_DIV;
            pis_pkg::ST_DIV:  if (c_valid[NC]) state_next = pis_pkg::ST_ACC;
            pis_pkg::ST_DONE: if (!m_valid_reg || m_ready) state_next = pis_pkg::ST_IDLE;
            default:          state_next = pis_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        ctrl    = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            pis_pkg::ST_IDLE: begin
                s_ready         = 1'b1;
                ctrl.load_first = s_valid;
            end
            pis_pkg::ST_ACC:  ctrl.step = 1'b1;
            pis_pkg::ST_MUL:  ctrl.launch = 1'b1;
            pis_pkg::ST_DIV:  ;
            pis_pkg::ST_DONE: ctrl.load_out = !m_valid_reg || m_ready;
            default:          ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pis_pkg::ST_IDLE;
            launch_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            launch_reg <= ctrl.launch;
            if (ctrl.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (ctrl.load_first) begin
            u_reg    <= s_uniform_fraction;
            term_reg <= first_reg;
            sum_reg  <= '0;
            idx_reg  <= '0;
        end else if (ctrl.step) begin
            sum_reg   <= sum_next;
            found_reg <= hit;
            if (!hit && !last) begin
                idx_reg <= idx_reg + 1'b1;
            end
        end else if (state_reg == pis_pkg::ST_DIV && c_valid[NC]) begin
            term_reg <= new_term;
        end
        if (ctrl.launch) begin
            p24_reg <= product[63:24];
        end
        if (ctrl.load_out) begin
            m_cnt_reg <= found_reg ? pis_pkg::COUNT_W'(idx_reg) : '0;
            m_nf_reg  <= !found_reg;
        end
    end

    // divider chain: dividend over term index
    assign c_valid[0] = launch_reg;
    assign c_num[0]   = p24_reg;
    assign c_rem[0]   = '0;
    assign c_quo[0]   = '0;
    assign c_div[0]   = idx_reg;

    for (genvar g = 0; g < NC; g++) begin : g_cell
        pis_div_cell #(.DIV_W(IDX_W)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (c_valid[g]),
            .in_num    (c_num[g]),
            .in_rem    (c_rem[g]),
            .in_quo    (c_quo[g]),
            .in_div    (c_div[g]),
            .out_valid (c_valid[g+1]),
            .out_num   (c_num[g+1]),
            .out_rem   (c_rem[g+1]),
            .out_quo   (c_quo[g+1]),
            .out_div   (c_div[g+1])
        );
    end

    assign m_valid        = m_valid_reg;
    assign m_sample_count = m_cnt_reg;
    assign m_not_found    = m_nf_reg;

endmodule

/* sv/pis_checker.sv */
// port-level checks for the poisson inverse sampler
`include "poisson_inverse_sampler_top_assert.svh"

module pis_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [pis_pkg::COUNT_W-1:0] m_sample_count,
    input logic                        m_not_found
);

    `PIS_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid, "result dropped while stalled")
    `PIS_ASSERT_IMPL(a_nf_zero, m_valid && m_not_found, m_sample_count == '0, "not found with count")
    `PIS_ASSERT(a_one_inflight, s_valid && s_ready |=> !s_ready, "second transaction taken early")
    `PIS_ASSERT_IMPL(a_ready_after, $rose(m_valid), s_ready, "input side not free after result")

endmodule

bind poisson_inverse_sampler_top pis_checker u_pis_checker (.*);
